@@ sv/sbs_pkg.sv @@
// Shared types and constants for the stroke Bezier smoother.
`timescale 1ns / 1ps

package sbs_pkg;

   // Field widths
   localparam int COORD_W = 24;
   localparam int WIDTH_W = 16;
   localparam int SAMPLES_PER_RESULT = 3;

   // Point commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_MOVE  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_MIN_SEGMENTS    = 2'd0,
      CSR_MAX_SEGMENTS    = 2'd1,
      CSR_SEGMENT_SPACING = 2'd2,
      CSR_SKIP_DISTANCE   = 2'd3
   } csr_index_type;

   // Iterative unit lengths: 50-bit radicand, 25-bit distance, 25-bit sample quotient
   localparam int SQRT_STEPS = 25;
   localparam int NDIV_STEPS = 25;
   localparam int QUOT_BITS  = 25;
   localparam int STEP_W     = 5;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [WIDTH_W-1:0]        point_width;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic [WIDTH_W-1:0]        first_width;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic [WIDTH_W-1:0]        second_width;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic [WIDTH_W-1:0]        third_width;
      logic [1:0]                sample_count;
      logic                      last_of_run;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       fill_start;
      logic       push_hist;
      logic       inc_hist;
      logic       skip_sq;
      logic       dist_sq;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       ndiv_init;
      logic       ndiv_step;
      logic       clamp;
      logic       coef;
      logic       mac;
      logic [1:0] mac_sel;
      logic       prep;
      logic       div_step;
      logic       store;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic [1:0] hist_count;
      logic       skip_hit;
      logic       slot_full;
      logic       last_sample;
      logic       rsp_last;
   } dp_status_type;

endpackage

@@ sv/sbs_ctrl.sv @@
// Sequencing state machine of the stroke Bezier smoother.
`timescale 1ns / 1ps

module sbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sbs_pkg::dp_status_type status,
   output sbs_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_SKIP_SQ, S_SKIP_CMP, S_DIST_SQ, S_SQRT_INIT, S_SQRT,
      S_NDIV_INIT, S_NDIV, S_CLAMP, S_COEF, S_MAC0, S_MAC1, S_MAC2, S_PREP,
      S_DIVS, S_STORE, S_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [sbs_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (status.command == sbs_pkg::CMD_START) begin
               cmd.fill_start = 1'b1;
               state_in       = S_DIST_SQ;
            end else if (status.command == sbs_pkg::CMD_MOVE &&
                         status.hist_count != 2'd0) begin
               state_in = S_SKIP_SQ;
            end else if (status.command == sbs_pkg::CMD_MOVE ||
                         status.command == sbs_pkg::CMD_END) begin
               if (status.hist_count < 2'd2) begin
                  cmd.push_hist = 1'b1;
                  cmd.inc_hist  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_DIST_SQ;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SKIP_SQ: begin
            cmd.skip_sq = 1'b1;
            state_in    = S_SKIP_CMP;
         end
         S_SKIP_CMP: begin
            priority if (status.skip_hit) begin
               state_in = S_IDLE;
            end else if (status.hist_count < 2'd2) begin
               cmd.push_hist = 1'b1;
               cmd.inc_hist  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_DIST_SQ;
            end
         end
         S_DIST_SQ: begin
            cmd.dist_sq = 1'b1;
            state_in    = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            step_in       = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == sbs_pkg::STEP_W'(sbs_pkg::SQRT_STEPS - 1)) begin
               state_in = S_NDIV_INIT;
            end
         end
         S_NDIV_INIT: begin
            cmd.ndiv_init = 1'b1;
            step_in       = '0;
            state_in      = S_NDIV;
         end
         S_NDIV: begin
            cmd.ndiv_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == sbs_pkg::STEP_W'(sbs_pkg::NDIV_STEPS - 1)) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_COEF;
         end
         S_COEF: begin
            cmd.coef = 1'b1;
            state_in = S_MAC0;
         end
         S_MAC0: begin
            cmd.mac     = 1'b1;
            cmd.mac_sel = 2'd0;
            state_in    = S_MAC1;
         end
         S_MAC1: begin
            cmd.mac     = 1'b1;
            cmd.mac_sel = 2'd1;
            state_in    = S_MAC2;
         end
         S_MAC2: begin
            cmd.mac     = 1'b1;
            cmd.mac_sel = 2'd2;
            state_in    = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == sbs_pkg::STEP_W'(sbs_pkg::QUOT_BITS - 1)) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (status.slot_full || status.last_sample) begin
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               state_in = S_COEF;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (status.rsp_last) begin
                  cmd.push_hist = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_COEF;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/sbs_datapath.sv @@
// Datapath of the stroke Bezier smoother: history, config, sqrt, dividers, blend lanes.
`timescale 1ns / 1ps

module sbs_datapath #(
   parameter int SEGMENT_LIMIT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sbs_pkg::dp_cmd_type    cmd,
   output sbs_pkg::dp_status_type status,
   input  sbs_pkg::req_type       req_payload,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output sbs_pkg::rsp_type       rsp_payload
);

   localparam int CW  = sbs_pkg::COORD_W;
   localparam int WW  = sbs_pkg::WIDTH_W;
   localparam int NW  = $clog2(SEGMENT_LIMIT + 1);
   localparam int KW  = 2 * NW;          // blend coefficient width
   localparam int OW  = CW + 2;          // lane operand width
   localparam int PW  = KW + 1 + OW;     // product width
   localparam int AW  = PW + 2;          // accumulator width
   localparam int QB  = sbs_pkg::QUOT_BITS;
   localparam int RW  = 2 * sbs_pkg::SQRT_STEPS;
   localparam int SRW = sbs_pkg::SQRT_STEPS + 2;
   localparam int DVW = WW + 1;
   localparam int NQW = sbs_pkg::NDIV_STEPS;
   localparam int SQW = 2 * (CW + 1);

   // Configuration
   logic [7:0]     min_seg_ff, max_seg_ff;
   logic [WW-1:0]  spacing_ff, skip_ff;

   // History and current item
   logic signed [CW-1:0] ox_ff, oy_ff, nx_ff, ny_ff, cx_ff, cy_ff;
   logic [WW-1:0]        ow_ff, nw_ff, cw_ff;
   logic [1:0]           hcount_ff, ccmd_ff;

   // Distance, sqrt and segment count
   logic [SQW-1:0]       sqa_ff, sqb_ff;
   logic [31:0]          skip2_ff;
   logic [RW-1:0]        rad_ff;
   logic [SRW-1:0]       srem_ff;
   logic [NQW-1:0]       root_ff;
   logic [DVW:0]         nrem_ff;
   logic [NW-1:0]        n_ff, j_ff;
   logic [1:0]           slot_ff;

   // Blend coefficients
   logic [KW-1:0]        aa_ff, ab4_ff, bb_ff, nn_ff;
   logic [KW:0]          den_ff;

   // Lanes: 0 x, 1 y, 2 width
   logic signed [AW-1:0] acc_ff [3];
   logic [AW-1:0]        rem_ff [3];
   logic [QB-1:0]        q_ff   [3];
   logic                 neg_ff [3];
   logic [AW-1:0]        dsh_ff;

   sbs_pkg::rsp_type     rsp_ff;

   // Operand selection per lane
   logic signed [OW-1:0] s1_op [3];
   logic signed [OW-1:0] md_op [3];
   logic signed [OW-1:0] s2_op [3];
   logic signed [QB-1:0] res   [3];

   always_comb begin
      s1_op[0] = OW'(ox_ff) + OW'(nx_ff);
      s1_op[1] = OW'(oy_ff) + OW'(ny_ff);
      s1_op[2] = OW'({1'b0, ow_ff}) + OW'({1'b0, nw_ff});
      md_op[0] = OW'(nx_ff);
      md_op[1] = OW'(ny_ff);
      md_op[2] = OW'({1'b0, nw_ff});
      s2_op[0] = OW'(nx_ff) + OW'(cx_ff);
      s2_op[1] = OW'(ny_ff) + OW'(cy_ff);
      s2_op[2] = OW'({1'b0, nw_ff}) + OW'({1'b0, cw_ff});
      for (int k = 0; k < 3; k++) begin
         res[k] = neg_ff[k] ? -$signed(q_ff[k]) : $signed(q_ff[k]);
      end
   end

   // Squared differences for the skip test and midpoint distance
   logic signed [CW:0] ex, ey;
   always_comb begin
      if (cmd.dist_sq) begin
         ex = (CW+1)'(cx_ff) - (CW+1)'(ox_ff);
         ey = (CW+1)'(cy_ff) - (CW+1)'(oy_ff);
      end else begin
         ex = (CW+1)'(cx_ff) - (CW+1)'(nx_ff);
         ey = (CW+1)'(cy_ff) - (CW+1)'(ny_ff);
      end
   end

   // Segment count clamp
   logic [NQW-1:0] nclamp;
   always_comb begin
      nclamp = root_ff;
      if (nclamp < NQW'(min_seg_ff)) nclamp = NQW'(min_seg_ff);
      if (nclamp > NQW'(max_seg_ff)) nclamp = NQW'(max_seg_ff);
      if (nclamp > NQW'(SEGMENT_LIMIT)) nclamp = NQW'(SEGMENT_LIMIT);
      if (nclamp == '0) nclamp = NQW'(1);
   end

   logic [NW-1:0]  a_val;
   logic [DVW-1:0] ndiv_den;
   logic [SRW-1:0] srem_cat, strial;
   logic [DVW:0]   nrem_cat;
   assign a_val    = n_ff - j_ff;
   assign ndiv_den = (spacing_ff == '0) ? DVW'(2) : {spacing_ff, 1'b0};
   assign srem_cat = {srem_ff[SRW-3:0], rad_ff[RW-1 -: 2]};
   assign strial   = {root_ff, 2'b01};
   assign nrem_cat = {nrem_ff[DVW-1:0], root_ff[NQW-1]};

   // Status to the controller
   always_comb begin
      status.command     = ccmd_ff;
      status.hist_count  = hcount_ff;
      status.skip_hit    = (SQW+1)'(sqa_ff) + (SQW+1)'(sqb_ff) < (SQW+1)'(skip2_ff);
      status.slot_full   = (slot_ff == 2'(sbs_pkg::SAMPLES_PER_RESULT - 1));
      status.last_sample = (j_ff == n_ff);
      status.rsp_last    = rsp_ff.last_of_run;
   end

   assign rsp_payload = rsp_ff;

   // Configuration and history, reset to defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         min_seg_ff <= 8'd32;
         max_seg_ff <= 8'd128;
         spacing_ff <= WW'(512);
         skip_ff    <= WW'(384);
         hcount_ff  <= 2'd0;
         ox_ff <= '0; oy_ff <= '0; ow_ff <= '0;
         nx_ff <= '0; ny_ff <= '0; nw_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (sbs_pkg::csr_index_type'(csr_index))
               sbs_pkg::CSR_MIN_SEGMENTS:    min_seg_ff <= csr_data[7:0];
               sbs_pkg::CSR_MAX_SEGMENTS:    max_seg_ff <= csr_data[7:0];
               sbs_pkg::CSR_SEGMENT_SPACING: spacing_ff <= csr_data;
               sbs_pkg::CSR_SKIP_DISTANCE:   skip_ff    <= csr_data;
               default: ;
            endcase
         end
         if (cmd.fill_start) begin
            ox_ff <= cx_ff; oy_ff <= cy_ff; ow_ff <= cw_ff;
            nx_ff <= cx_ff; ny_ff <= cy_ff; nw_ff <= cw_ff;
            hcount_ff <= 2'd2;
         end else if (cmd.push_hist) begin
            ox_ff <= nx_ff; oy_ff <= ny_ff; ow_ff <= nw_ff;
            nx_ff <= cx_ff; ny_ff <= cy_ff; nw_ff <= cw_ff;
            if (cmd.inc_hist) hcount_ff <= hcount_ff + 2'd1;
         end
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         ccmd_ff <= req_payload.command;
         cx_ff   <= req_payload.point_x;
         cy_ff   <= req_payload.point_y;
         cw_ff   <= req_payload.point_width;
      end
      if (cmd.skip_sq || cmd.dist_sq) begin
         sqa_ff   <= SQW'(ex * ex);
         sqb_ff   <= SQW'(ey * ey);
         skip2_ff <= 32'(skip_ff * skip_ff);
      end
      // Integer square root, two radicand bits per step
      if (cmd.sqrt_init) begin
         rad_ff  <= RW'(sqa_ff) + RW'(sqb_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (srem_cat >= strial) begin
            srem_ff <= srem_cat - strial;
            root_ff <= {root_ff[NQW-2:0], 1'b1};
         end else begin
            srem_ff <= srem_cat;
            root_ff <= {root_ff[NQW-2:0], 1'b0};
         end
      end
      // Distance over twice the spacing, quotient built in place of the root
      if (cmd.ndiv_init) begin
         nrem_ff <= '0;
      end else if (cmd.ndiv_step) begin
         if (nrem_cat >= (DVW+1)'(ndiv_den)) begin
            nrem_ff <= nrem_cat - (DVW+1)'(ndiv_den);
            root_ff <= {root_ff[NQW-2:0], 1'b1};
         end else begin
            nrem_ff <= nrem_cat;
            root_ff <= {root_ff[NQW-2:0], 1'b0};
         end
      end
      if (cmd.clamp) begin
         n_ff    <= NW'(nclamp);
         j_ff    <= '0;
         slot_ff <= '0;
      end
      // Blend coefficients for t = j/n
      if (cmd.coef) begin
         aa_ff  <= KW'(a_val * a_val);
         ab4_ff <= KW'((a_val * j_ff) << 2);
         bb_ff  <= KW'(j_ff * j_ff);
         nn_ff  <= KW'(n_ff * n_ff);
         den_ff <= (KW+1)'(n_ff * n_ff) << 1;
      end
      for (int k = 0; k < 3; k++) begin
         if (cmd.coef) begin
            acc_ff[k] <= '0;
         end else if (cmd.mac) begin
            unique case (cmd.mac_sel)
               2'd0:    acc_ff[k] <= acc_ff[k] + AW'($signed({1'b0, aa_ff}) * s1_op[k]);
               2'd1:    acc_ff[k] <= acc_ff[k] + AW'($signed({1'b0, ab4_ff}) * md_op[k]);
               default: acc_ff[k] <= acc_ff[k] + AW'($signed({1'b0, bb_ff}) * s2_op[k]);
            endcase
         end
      end
      // Floor divide by 2n^2 with magnitude restoring steps
      if (cmd.prep) begin
         dsh_ff <= AW'(den_ff) << (QB - 1);
         for (int k = 0; k < 3; k++) begin
            logic signed [AW-1:0] nsum;
            nsum      = acc_ff[k] + AW'(nn_ff);
            neg_ff[k] <= nsum[AW-1];
            rem_ff[k] <= nsum[AW-1] ? AW'(-nsum + AW'(den_ff) - AW'(1)) : AW'(nsum);
            q_ff[k]   <= '0;
         end
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         for (int k = 0; k < 3; k++) begin
            if (rem_ff[k] >= dsh_ff) begin
               rem_ff[k] <= rem_ff[k] - dsh_ff;
               q_ff[k]   <= {q_ff[k][QB-2:0], 1'b1};
            end else begin
               q_ff[k]   <= {q_ff[k][QB-2:0], 1'b0};
            end
         end
      end
      // Pack the sample into its slot; a fresh result clears the other slots
      if (cmd.store) begin
         rsp_ff.sample_count <= slot_ff + 2'd1;
         rsp_ff.last_of_run  <= (j_ff == n_ff);
         unique case (slot_ff)
            2'd0: begin
               rsp_ff.first_x      <= CW'(res[0]);
               rsp_ff.first_y      <= CW'(res[1]);
               rsp_ff.first_width  <= WW'(res[2]);
               rsp_ff.second_x     <= '0;
               rsp_ff.second_y     <= '0;
               rsp_ff.second_width <= '0;
               rsp_ff.third_x      <= '0;
               rsp_ff.third_y      <= '0;
               rsp_ff.third_width  <= '0;
            end
            2'd1: begin
               rsp_ff.second_x     <= CW'(res[0]);
               rsp_ff.second_y     <= CW'(res[1]);
               rsp_ff.second_width <= WW'(res[2]);
            end
            default: begin
               rsp_ff.third_x      <= CW'(res[0]);
               rsp_ff.third_y      <= CW'(res[1]);
               rsp_ff.third_width  <= WW'(res[2]);
            end
         endcase
         j_ff    <= j_ff + 1'b1;
         slot_ff <= status.slot_full ? 2'd0 : slot_ff + 2'd1;
      end
   end

endmodule

@@ sv/stroke_bezier_smoother.sv @@
// Top level of the stroke Bezier smoother.
//
// Stroke points enter on req_ (valid/ready), one transaction per point with a
// command (start, move, end), position and width. Quadratic Bezier samples
// leave on rsp_, up to three samples per transaction, last_of_run marking the
// final transaction of a point. Registers are written on csr_ (always ready);
// the user must write them only while the block is idle; it is not enforced.
// One point is processed at a time; req_ready is high only when idle.
// Distance work for a point: decode, skip test (move only), squares,
// 25-step square root, 25-step divide and clamp; then for each sample the
// coefficients, three multiply-accumulate steps, a 25-step restoring divide
// run side by side on the x, y and width lanes, and the store, with each
// result transaction offered until taken. A point of n segments yields n+1
// samples. A dropped or history-only point returns to idle after the decode
// or the skip test.
// When rsp_ready is low the result register holds and the sample sequencer
// waits. Synchronous reset clears the history and restores register defaults.
`timescale 1ns / 1ps

module stroke_bezier_smoother #(
   parameter int SEGMENT_LIMIT = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbs_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   sbs_pkg::dp_cmd_type    cmd;
   sbs_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   sbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbs_datapath #(
      .SEGMENT_LIMIT (SEGMENT_LIMIT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sv/sbs_checker.sv @@
// Port-level checks for the stroke Bezier smoother, bound to the top level.
`timescale 1ns / 1ps

module sbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sbs_pkg::rsp_type rsp_payload
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // No new point while a result waits
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input ready while result pending");

   // Every result carries samples
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.sample_count != 2'd0)
      else $error("empty result");

   // Reset clears the result channel
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stroke_bezier_smoother sbs_checker u_sbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
